[rtl/lsse_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package lsse_pkg;
	typedef enum logic [4:0] {
		K_ST_RR_A = 5'd0, K_LD_R_R = 5'd1, K_LD_R_N = 5'd2, K_ST_HL_N = 5'd3,
		K_LD_A_RR = 5'd4, K_ST_HL_R = 5'd5, K_LD_R_HL = 5'd6, K_ST_NN_A = 5'd7,
		K_LD_A_NN = 5'd8, K_ST_HLI = 5'd9, K_ST_HLD = 5'd10, K_LD_HLI = 5'd11,
		K_LD_HLD = 5'd12, K_LD_RR_NN = 5'd13, K_LD_SP_NN = 5'd14, K_ST_NN_SP = 5'd15,
		K_LD_HL_SPE = 5'd16, K_LD_SP_HL = 5'd17, K_STH_N = 5'd18, K_LDH_N = 5'd19,
		K_LDH_C = 5'd20, K_STH_C = 5'd21, K_POP = 5'd22, K_POP_AF = 5'd23,
		K_PUSH = 5'd24, K_FILL = 5'd25
	} kind_t;

	localparam logic [7:0] HIGH_PAGE = 8'hFF;

	typedef struct packed {
		logic [4:0]  kind;
		logic [2:0]  dest_sel;
		logic [2:0]  source_sel;
		logic [1:0]  pair_sel;
		logic [15:0] fill_address;
		logic [7:0]  fill_data;
	} in_beat_t;

	typedef struct packed {
		logic [2:0]  machine_cycles;
		logic [7:0]  acc_value;
		logic [3:0]  flag_bits;
		logic [15:0] bc_value;
		logic [15:0] de_value;
		logic [15:0] hl_value;
		logic [15:0] stack_value;
		logic [15:0] counter_value;
	} out_beat_t;

	typedef enum logic [3:0] {
		A_PC, A_PAIR, A_HL, A_NN, A_NN1, A_HIGH_T, A_HIGH_C, A_SP, A_SPM1, A_SPM2, A_FILL,
		A_CLR
	} addr_sel_t;

	typedef enum logic [3:0] {
		W_NONE, W_ACC, W_REG, W_T, W_SPL, W_SPH, W_PHI, W_PLO, W_FILL, W_ZERO
	} wsel_t;

	typedef enum logic [3:0] {
		X_NONE, X_REG_REG, X_REG_RD, X_ACC_RD, X_T_RD, X_U_RD, X_PAIR_TU,
		X_SP_TU, X_HL_INC, X_HL_DEC, X_HL_SPE, X_SP_HL, X_PC_INC, X_SP_INC, X_SP_DEC2,
		X_RD_T
	} xop_t;

	typedef struct packed {
		logic      mem_en;
		logic      mem_we;
		addr_sel_t asel;
		wsel_t     wsel;
		xop_t      op;
		logic      pop_af;
		logic      load_in;
		logic [2:0] cycles;
		logic      capture;
	} cmd_t;
endpackage
`default_nettype wire

[rtl/lsse_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
module lsse_ram #(
	parameter int Width = 8,
	parameter int Depth = 65536
) (
	input  wire logic                     clk,
	input  wire logic                     en,
	input  wire logic                     we,
	input  wire logic [$clog2(Depth)-1:0] addr,
	input  wire logic [Width-1:0]         wdata,
	output logic      [Width-1:0]         rdata
);
	logic [Width-1:0] mem [Depth];
	always_ff @(posedge clk) begin
		if (en) begin
			if (we) mem[addr] <= wdata;
			else rdata <= mem[addr];
		end
	end
endmodule
`default_nettype wire

[rtl/lsse_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none
module lsse_datapath import lsse_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire cmd_t      cmd,
	input  wire in_beat_t  in_beat,
	input  wire logic [15:0] clr_addr,
	output in_beat_t       cur,
	output out_beat_t      res
);
	logic [7:0]  acc_q, b_q, c_q, d_q, e_q, h_q, l_q, t_q, u_q;
	logic [3:0]  flag_q;
	logic [15:0] sp_q, pc_q, addr, pair, hl, nn;
	logic [7:0]  wdata, rd, src_r;
	logic [8:0]  sum_lo;
	logic [4:0]  sum_n;
	logic [15:0] spe;
	logic [2:0]  cyc_q;

	assign hl = {h_q, l_q};
	assign nn = {u_q, t_q};
	always_comb begin
		case (cur.pair_sel)
			2'd0: pair = {b_q, c_q};
			2'd1: pair = {d_q, e_q};
			2'd2: pair = hl;
			default: pair = {acc_q, flag_q, 4'h0};
		endcase
		case (cur.source_sel)
			3'd0: src_r = b_q;
			3'd1: src_r = c_q;
			3'd2: src_r = d_q;
			3'd3: src_r = e_q;
			3'd4: src_r = h_q;
			3'd5: src_r = l_q;
			3'd7: src_r = acc_q;
			default: src_r = 8'h00;
		endcase
		unique case (cmd.asel)
			A_PC:     addr = pc_q;
			A_PAIR:   addr = pair;
			A_HL:     addr = hl;
			A_NN:     addr = nn;
			A_NN1:    addr = nn + 16'd1;
			A_HIGH_T: addr = {HIGH_PAGE, t_q};
			A_HIGH_C: addr = {HIGH_PAGE, c_q};
			A_SP:     addr = sp_q;
			A_SPM1:   addr = sp_q - 16'd1;
			A_SPM2:   addr = sp_q - 16'd2;
			A_FILL:   addr = in_beat.fill_address;
			default:  addr = clr_addr;
		endcase
		unique case (cmd.wsel)
			W_ACC:  wdata = acc_q;
			W_REG:  wdata = src_r;
			W_T:    wdata = t_q;
			W_SPL:  wdata = sp_q[7:0];
			W_SPH:  wdata = sp_q[15:8];
			W_PHI:  wdata = pair[15:8];
			W_PLO:  wdata = pair[7:0];
			W_FILL: wdata = in_beat.fill_data;
			default: wdata = 8'h00;
		endcase
	end

	lsse_ram #(.Width(8), .Depth(65536)) u_mem (
		.clk(clk), .en(cmd.mem_en), .we(cmd.mem_we), .addr(addr), .wdata(wdata), .rdata(rd)
	);

	assign sum_lo = {1'b0, sp_q[7:0]} + {1'b0, t_q};
	assign sum_n  = {1'b0, sp_q[3:0]} + {1'b0, t_q[3:0]};
	assign spe    = sp_q + {{8{t_q[7]}}, t_q};

	always_ff @(posedge clk) begin
		if (cmd.load_in) cur <= in_beat;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0; b_q <= '0; c_q <= '0; d_q <= '0; e_q <= '0; h_q <= '0; l_q <= '0;
			flag_q <= '0; sp_q <= '0; pc_q <= '0; t_q <= '0; u_q <= '0; cyc_q <= '0;
		end else begin
			if (cmd.capture) cyc_q <= cmd.cycles;
			unique case (cmd.op) inside
				X_REG_REG, X_REG_RD: begin
					logic [7:0] v;
					v = (cmd.op == X_REG_REG) ? src_r : rd;
					case (cur.dest_sel)
						3'd0: b_q <= v;
						3'd1: c_q <= v;
						3'd2: d_q <= v;
						3'd3: e_q <= v;
						3'd4: h_q <= v;
						3'd5: l_q <= v;
						3'd7: acc_q <= v;
						default: ;
					endcase
				end
				X_ACC_RD: acc_q <= rd;
				X_RD_T:   t_q <= rd;
				X_T_RD:   begin t_q <= rd; pc_q <= pc_q + 16'd1; end
				X_U_RD:   u_q <= rd;
				X_PC_INC: pc_q <= pc_q + 16'd1;
				X_PAIR_TU: begin
					if (cmd.pop_af || cur.pair_sel == 2'd3) begin
						acc_q <= u_q; flag_q <= t_q[7:4];
					end else begin
						case (cur.pair_sel)
							2'd0: begin b_q <= u_q; c_q <= t_q; end
							2'd1: begin d_q <= u_q; e_q <= t_q; end
							default: begin h_q <= u_q; l_q <= t_q; end
						endcase
					end
				end
				X_SP_TU:   sp_q <= nn;
				X_HL_INC:  {h_q, l_q} <= hl + 16'd1;
				X_HL_DEC:  {h_q, l_q} <= hl - 16'd1;
				X_HL_SPE: begin
					{h_q, l_q} <= spe;
					flag_q <= {2'b00, sum_n[4], sum_lo[8]};
				end
				X_SP_HL:   sp_q <= hl;
				X_SP_INC:  sp_q <= sp_q + 16'd1;
				X_SP_DEC2: sp_q <= sp_q - 16'd2;
				default: ;
			endcase
		end
	end

	assign res = '{machine_cycles: cyc_q, acc_value: acc_q, flag_bits: flag_q,
		bc_value: {b_q, c_q}, de_value: {d_q, e_q}, hl_value: hl,
		stack_value: sp_q, counter_value: pc_q};
endmodule
`default_nettype wire

[rtl/lsse_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
module lsse_ctrl import lsse_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	input  wire in_beat_t in_beat,
	input  wire in_beat_t cur,
	output logic          in_ready,
	output logic          out_valid,
	input  wire logic     out_ready,
	output cmd_t          cmd,
	output logic [15:0]   clr_addr
);
	typedef enum logic [1:0] {S_CLR, S_IDLE, S_RUN, S_DONE} state_t;
	state_t     state_q;
	logic [2:0] step_q;
	logic [15:0] clr_q;
	kind_t      k;
	logic [2:0] last;

	assign k = kind_t'(cur.kind);
	assign clr_addr = clr_q;
	assign in_ready = (state_q == S_IDLE);
	assign out_valid = (state_q == S_DONE);

	always_comb begin
		cmd = '{mem_en: 1'b0, mem_we: 1'b0, asel: A_PC, wsel: W_NONE, op: X_NONE,
			pop_af: 1'b0, load_in: 1'b0, cycles: 3'd0, capture: 1'b0};
		unique case (state_q)
			S_CLR: begin
				cmd.mem_en = 1'b1; cmd.mem_we = 1'b1; cmd.asel = A_CLR; cmd.wsel = W_ZERO;
			end
			S_IDLE: begin
				cmd.load_in = in_valid;
				if (in_valid && in_beat.kind == K_FILL) begin
					cmd.mem_en = 1'b1; cmd.mem_we = 1'b1; cmd.asel = A_FILL; cmd.wsel = W_FILL;
				end
			end
			S_RUN: begin
				cmd.capture = 1'b1;
				case (k) inside
					K_ST_RR_A: begin cmd.cycles = 3'd2; cmd.mem_en = 1'b1; cmd.mem_we = 1'b1;
						cmd.asel = A_PAIR; cmd.wsel = W_ACC; end
					K_LD_R_R: begin cmd.cycles = 3'd1; cmd.op = X_REG_REG; end
					K_LD_R_N: begin cmd.cycles = 3'd2;
						if (step_q == 0) begin cmd.mem_en = 1'b1; cmd.op = X_PC_INC; end
						else cmd.op = X_REG_RD; end
					K_ST_HL_N: begin cmd.cycles = 3'd3;
						if (step_q == 0) begin cmd.mem_en = 1'b1; cmd.op = X_PC_INC; end
						else if (step_q == 1) cmd.op = X_RD_T;
						else begin cmd.mem_en = 1'b1; cmd.mem_we = 1'b1; cmd.asel = A_HL;
							cmd.wsel = W_T; end end
					K_LD_A_RR: begin cmd.cycles = 3'd2;
						if (step_q == 0) begin cmd.mem_en = 1'b1; cmd.asel = A_PAIR; end
						else cmd.op = X_ACC_RD; end
					K_ST_HL_R: begin cmd.cycles = 3'd2; cmd.mem_en = 1'b1; cmd.mem_we = 1'b1;
						cmd.asel = A_HL; cmd.wsel = W_REG; end
					K_LD_R_HL: begin cmd.cycles = 3'd2;
						if (step_q == 0) begin cmd.mem_en = 1'b1; cmd.asel = A_HL; end
						else cmd.op = X_REG_RD; end
					K_ST_HLI, K_ST_HLD: begin cmd.cycles = 3'd2;
						if (step_q == 0) begin cmd.mem_en = 1'b1; cmd.mem_we = 1'b1;
							cmd.asel = A_HL; cmd.wsel = W_ACC; end
						else cmd.op = (k == K_ST_HLI) ? X_HL_INC : X_HL_DEC; end
					K_LD_HLI, K_LD_HLD: begin cmd.cycles = 3'd2;
						if (step_q == 0) begin cmd.mem_en = 1'b1; cmd.asel = A_HL; end
						else if (step_q == 1) cmd.op = X_ACC_RD;
						else cmd.op = (k == K_LD_HLI) ? X_HL_INC : X_HL_DEC; end
					K_LD_SP_HL: begin cmd.cycles = 3'd2; cmd.op = X_SP_HL; end
					K_LDH_C: begin cmd.cycles = 3'd2;
						if (step_q == 0) begin cmd.mem_en = 1'b1; cmd.asel = A_HIGH_C; end
						else cmd.op = X_ACC_RD; end
					K_STH_C: begin cmd.cycles = 3'd2; cmd.mem_en = 1'b1; cmd.mem_we = 1'b1;
						cmd.asel = A_HIGH_C; cmd.wsel = W_ACC; end
					K_LD_HL_SPE, K_STH_N, K_LDH_N: begin cmd.cycles = 3'd3;
						if (step_q == 0) begin cmd.mem_en = 1'b1; cmd.op = X_PC_INC; end
						else if (step_q == 1) cmd.op = X_RD_T;
						else if (k == K_LD_HL_SPE) cmd.op = X_HL_SPE;
						else if (k == K_STH_N) begin cmd.mem_en = 1'b1; cmd.mem_we = 1'b1;
							cmd.asel = A_HIGH_T; cmd.wsel = W_ACC; end
						else if (step_q == 2) begin cmd.mem_en = 1'b1; cmd.asel = A_HIGH_T; end
						else cmd.op = X_ACC_RD; end
					K_ST_NN_A, K_LD_A_NN, K_LD_RR_NN, K_LD_SP_NN, K_ST_NN_SP: begin
						cmd.cycles = (k == K_ST_NN_SP) ? 3'd5 :
							(k == K_LD_RR_NN || k == K_LD_SP_NN) ? 3'd3 : 3'd4;
						if (step_q == 0) begin cmd.mem_en = 1'b1; cmd.op = X_PC_INC; end
						else if (step_q == 1) begin cmd.mem_en = 1'b1; cmd.op = X_T_RD; end
						else if (step_q == 2) cmd.op = X_U_RD;
						else begin
							case (k)
								K_LD_RR_NN: cmd.op = X_PAIR_TU;
								K_LD_SP_NN: cmd.op = X_SP_TU;
								K_ST_NN_A: begin cmd.mem_en = 1'b1; cmd.mem_we = 1'b1;
									cmd.asel = A_NN; cmd.wsel = W_ACC; end
								K_LD_A_NN: if (step_q == 3) begin cmd.mem_en = 1'b1;
									cmd.asel = A_NN; end else cmd.op = X_ACC_RD;
								default: begin cmd.mem_en = 1'b1; cmd.mem_we = 1'b1;
									cmd.asel = (step_q == 3) ? A_NN : A_NN1;
									cmd.wsel = (step_q == 3) ? W_SPL : W_SPH; end
							endcase
						end
					end
					K_POP, K_POP_AF: begin cmd.cycles = 3'd3;
						cmd.pop_af = (k == K_POP_AF);
						if (step_q == 0) begin cmd.mem_en = 1'b1; cmd.asel = A_SP;
							cmd.op = X_SP_INC; end
						else if (step_q == 1) cmd.op = X_RD_T;
						else if (step_q == 2) begin cmd.mem_en = 1'b1; cmd.asel = A_SP;
							cmd.op = X_SP_INC; end
						else if (step_q == 3) cmd.op = X_U_RD;
						else cmd.op = X_PAIR_TU; end
					K_PUSH: begin cmd.cycles = 3'd4;
						if (step_q == 0) begin cmd.mem_en = 1'b1; cmd.mem_we = 1'b1;
							cmd.asel = A_SPM1; cmd.wsel = W_PHI; end
						else if (step_q == 1) begin cmd.mem_en = 1'b1; cmd.mem_we = 1'b1;
							cmd.asel = A_SPM2; cmd.wsel = W_PLO; end
						else cmd.op = X_SP_DEC2; end
					default: cmd.cycles = 3'd0;
				endcase
			end
			default: ;
		endcase
	end

	always_comb begin
		case (k) inside
			K_LD_R_N, K_LD_A_RR, K_LD_R_HL, K_ST_HLI, K_ST_HLD, K_LDH_C: last = 3'd1;
			K_ST_HL_N, K_LD_HL_SPE, K_STH_N, K_LD_HLI, K_LD_HLD, K_PUSH: last = 3'd2;
			K_LDH_N, K_LD_RR_NN, K_LD_SP_NN, K_ST_NN_A: last = 3'd3;
			K_LD_A_NN, K_ST_NN_SP, K_POP, K_POP_AF: last = 3'd4;
			default: last = 3'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			step_q <= '0;
			clr_q <= '0;
		end else begin
			unique case (state_q)
				S_CLR: begin
					clr_q <= clr_q + 16'd1;
					if (clr_q == 16'hFFFF) state_q <= S_IDLE;
				end
				S_IDLE: if (in_valid) begin
					step_q <= '0;
					state_q <= S_RUN;
				end
				S_RUN: begin
					if (step_q == last) state_q <= S_DONE;
					else step_q <= step_q + 3'd1;
				end
				S_DONE: if (out_ready) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

[rtl/cpu_load_store_stack_execute_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// An instruction runs as a sequence of steps from accept to result: one step per memory access or
// register update, set by the single-port byte memory, then a step that presents the result.
// A host fill writes its byte as it is accepted. One item is in flight at a time, so a new beat
// is accepted only after the previous result has been taken.
// After reset the memory is swept to zero, one byte per cycle, over all 65536 bytes with ready low.
// All CPU registers (A, flags, BC, DE, HL, SP, PC) reset to zero.
module cpu_load_store_stack_execute_core import lsse_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_ready,
	input  wire in_beat_t  in_data,
	output logic           out_valid,
	input  wire logic      out_ready,
	output out_beat_t      out_data
);
	cmd_t        cmd;
	in_beat_t    cur;
	logic [15:0] clr_addr;

	lsse_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_beat(in_data), .cur(cur),
		.in_ready(in_ready), .out_valid(out_valid), .out_ready(out_ready), .cmd(cmd),
		.clr_addr(clr_addr)
	);

	lsse_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .in_beat(in_data), .clr_addr(clr_addr),
		.cur(cur), .res(out_data)
	);
endmodule
`default_nettype wire

[tb/sv/lsse_checker.sv]
`timescale 1ns / 1ps
module lsse_checker import lsse_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	input  wire logic      in_ready,
	input  wire in_beat_t  in_data,
	input  wire logic      out_valid,
	input  wire logic      out_ready,
	input  wire out_beat_t out_data,
	output int             fail_count,
	output int             pending_count
);
	logic [7:0] mem_img [0:65535];
	logic [7:0] acc, regs [0:5];
	logic [3:0] flags;
	logic [15:0] sp, pc;
	out_beat_t snapshot_q[$];

	function automatic logic [7:0] read_reg(logic [2:0] s);
		if (s == 3'd7) return acc;
		if (s < 3'd6) return regs[s];
		return 8'h00;
	endfunction

	function automatic void write_reg(logic [2:0] s, logic [7:0] v);
		if (s == 3'd7) acc = v;
		else if (s < 3'd6) regs[s] = v;
	endfunction

	function automatic logic [15:0] read_pair(logic [1:0] p);
		if (p == 2'd3) return {acc, flags, 4'h0};
		return {regs[2 * p], regs[2 * p + 1]};
	endfunction

	function automatic void write_pair(logic [1:0] p, logic [15:0] v);
		if (p == 2'd3) begin
			acc = v[15:8];
			flags = v[7:4];
		end else begin
			regs[2 * p] = v[15:8];
			regs[2 * p + 1] = v[7:0];
		end
	endfunction

	function automatic logic [7:0] fetch_byte();
		logic [7:0] v;
		v = mem_img[pc];
		pc = pc + 16'd1;
		return v;
	endfunction

	function automatic logic [15:0] fetch_word();
		logic [7:0] lo;
		lo = fetch_byte();
		return {fetch_byte(), lo};
	endfunction

	function automatic void execute(in_beat_t b);
		logic [15:0] a, hl;
		logic [7:0] t, lo;
		logic [2:0] cyc;
		logic [8:0] sum;
		logic [4:0] nib;
		out_beat_t r;
		cyc = 3'd0;
		case (b.kind) inside
			K_ST_RR_A: begin mem_img[read_pair(b.pair_sel)] = acc; cyc = 3'd2; end
			K_LD_R_R: begin write_reg(b.dest_sel, read_reg(b.source_sel)); cyc = 3'd1; end
			K_LD_R_N: begin write_reg(b.dest_sel, fetch_byte()); cyc = 3'd2; end
			K_ST_HL_N: begin t = fetch_byte(); mem_img[read_pair(2'd2)] = t; cyc = 3'd3; end
			K_LD_A_RR: begin acc = mem_img[read_pair(b.pair_sel)]; cyc = 3'd2; end
			K_ST_HL_R: begin mem_img[read_pair(2'd2)] = read_reg(b.source_sel); cyc = 3'd2; end
			K_LD_R_HL: begin write_reg(b.dest_sel, mem_img[read_pair(2'd2)]); cyc = 3'd2; end
			K_ST_NN_A: begin a = fetch_word(); mem_img[a] = acc; cyc = 3'd4; end
			K_LD_A_NN: begin a = fetch_word(); acc = mem_img[a]; cyc = 3'd4; end
			K_ST_HLI, K_ST_HLD, K_LD_HLI, K_LD_HLD: begin
				hl = read_pair(2'd2);
				if (b.kind == K_ST_HLI || b.kind == K_ST_HLD) mem_img[hl] = acc;
				else acc = mem_img[hl];
				if (b.kind == K_ST_HLI || b.kind == K_LD_HLI) hl = hl + 16'd1;
				else hl = hl - 16'd1;
				write_pair(2'd2, hl);
				cyc = 3'd2;
			end
			K_LD_RR_NN: begin write_pair(b.pair_sel, fetch_word()); cyc = 3'd3; end
			K_LD_SP_NN: begin sp = fetch_word(); cyc = 3'd3; end
			K_ST_NN_SP: begin
				a = fetch_word();
				mem_img[a] = sp[7:0];
				mem_img[a + 16'd1] = sp[15:8];
				cyc = 3'd5;
			end
			K_LD_HL_SPE: begin
				t = fetch_byte();
				nib = {1'b0, sp[3:0]} + {1'b0, t[3:0]};
				sum = {1'b0, sp[7:0]} + {1'b0, t};
				write_pair(2'd2, sp + {{8{t[7]}}, t});
				flags = {2'b00, nib[4], sum[8]};
				cyc = 3'd3;
			end
			K_LD_SP_HL: begin sp = read_pair(2'd2); cyc = 3'd2; end
			K_STH_N: begin t = fetch_byte(); mem_img[{HIGH_PAGE, t}] = acc; cyc = 3'd3; end
			K_LDH_N: begin t = fetch_byte(); acc = mem_img[{HIGH_PAGE, t}]; cyc = 3'd3; end
			K_LDH_C: begin acc = mem_img[{HIGH_PAGE, regs[1]}]; cyc = 3'd2; end
			K_STH_C: begin mem_img[{HIGH_PAGE, regs[1]}] = acc; cyc = 3'd2; end
			K_POP, K_POP_AF: begin
				lo = mem_img[sp];
				sp = sp + 16'd1;
				t = mem_img[sp];
				sp = sp + 16'd1;
				write_pair((b.kind == K_POP_AF) ? 2'd3 : b.pair_sel, {t, lo});
				cyc = 3'd3;
			end
			K_PUSH: begin
				a = read_pair(b.pair_sel);
				sp = sp - 16'd1;
				mem_img[sp] = a[15:8];
				sp = sp - 16'd1;
				mem_img[sp] = a[7:0];
				cyc = 3'd4;
			end
			K_FILL: mem_img[b.fill_address] = b.fill_data;
			default: ;
		endcase
		r.machine_cycles = cyc;
		r.acc_value = acc;
		r.flag_bits = flags;
		r.bc_value = read_pair(2'd0);
		r.de_value = read_pair(2'd1);
		r.hl_value = read_pair(2'd2);
		r.stack_value = sp;
		r.counter_value = pc;
		snapshot_q.push_back(r);
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("%0t mismatch %s: got %h expected %h", $realtime, what, got, want);
		fail_count++;
	endtask

	initial begin
		fail_count = 0;
		acc = '0;
		flags = '0;
		sp = '0;
		pc = '0;
		for (int i = 0; i < 6; i++) regs[i] = '0;
		for (int i = 0; i < 65536; i++) mem_img[i] = '0;
	end

	assign pending_count = snapshot_q.size();

	always @(posedge clk) begin
		out_beat_t e;
		if (arst_n && out_valid && out_ready) begin
			if (snapshot_q.size() == 0) begin
				$display("%0t result beat with none expected", $realtime);
				fail_count++;
			end else begin
				e = snapshot_q.pop_front();
				if (out_data.machine_cycles !== e.machine_cycles)
					report_mismatch("machine_cycles", int'(out_data.machine_cycles),
						int'(e.machine_cycles));
				if (out_data.acc_value !== e.acc_value)
					report_mismatch("acc_value", int'(out_data.acc_value), int'(e.acc_value));
				if (out_data.flag_bits !== e.flag_bits)
					report_mismatch("flag_bits", int'(out_data.flag_bits), int'(e.flag_bits));
				if (out_data.bc_value !== e.bc_value)
					report_mismatch("bc_value", int'(out_data.bc_value), int'(e.bc_value));
				if (out_data.de_value !== e.de_value)
					report_mismatch("de_value", int'(out_data.de_value), int'(e.de_value));
				if (out_data.hl_value !== e.hl_value)
					report_mismatch("hl_value", int'(out_data.hl_value), int'(e.hl_value));
				if (out_data.stack_value !== e.stack_value)
					report_mismatch("stack_value", int'(out_data.stack_value),
						int'(e.stack_value));
				if (out_data.counter_value !== e.counter_value)
					report_mismatch("counter_value", int'(out_data.counter_value),
						int'(e.counter_value));
			end
		end
		if (arst_n && in_valid && in_ready) execute(in_data);
	end
endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps
module tb_top;
	import lsse_pkg::*;

	logic clk, arst_n, in_valid, in_ready, out_valid, out_ready;
	in_beat_t in_data;
	out_beat_t out_data;
	int fail_count, pending_count;
	int send_idle_pct, recv_idle_pct;

	cpu_load_store_stack_execute_core dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

	lsse_checker checker_i (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.fail_count(fail_count), .pending_count(pending_count)
	);

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	initial begin
		#50ms;
		$display("tb_top failed");
		$finish;
	end

	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	task automatic send_beat(in_beat_t b);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= b;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	function automatic in_beat_t make_op(kind_t k, logic [2:0] d, logic [2:0] s, logic [1:0] p);
		in_beat_t b;
		b = in_beat_t'($bits(in_beat_t)'({$urandom, $urandom}));
		b.kind = k;
		b.dest_sel = d;
		b.source_sel = s;
		b.pair_sel = p;
		return b;
	endfunction

	function automatic in_beat_t make_fill(logic [15:0] a, logic [7:0] v);
		in_beat_t b;
		b = make_op(K_FILL, 3'($urandom), 3'($urandom), 2'($urandom));
		b.fill_address = a;
		b.fill_data = v;
		return b;
	endfunction

	function automatic in_beat_t make_random();
		in_beat_t b;
		b = in_beat_t'($bits(in_beat_t)'({$urandom, $urandom}));
		case ($urandom_range(9)) inside
			0, 1, 2: b.kind = K_FILL;
			3: b.kind = 5'($urandom_range(31));
			default: b.kind = 5'($urandom_range(24));
		endcase
		if ($urandom_range(3) == 0) b.fill_address = 16'hFF00 | 16'($urandom_range(255));
		return b;
	endfunction

	task automatic run_phase(int n);
		for (int i = 0; i < n; i++) begin
			// Seed the bytes at PC so immediates are random rather than mostly zero.
			if ($urandom_range(1)) send_beat(make_fill(checker_i.pc, 8'($urandom)));
			send_beat(make_random());
		end
	endtask

	initial begin
		in_valid = 0;
		in_data = '0;
		out_ready = 0;
		arst_n = 0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1;

		send_beat(make_fill(16'h0000, 8'h34));
		send_beat(make_fill(16'h0001, 8'hFF));
		send_beat(make_fill(16'h0002, 8'h80));
		send_beat(make_fill(16'hFFFF, 8'hFF));
		send_beat(make_op(K_LD_RR_NN, 3'd0, 3'd0, 2'd2));
		send_beat(make_op(K_LD_HL_SPE, 3'd0, 3'd0, 2'd0));
		send_beat(make_op(K_LD_R_R, 3'd7, 3'd4, 2'd0));
		send_beat(make_op(K_LD_R_R, 3'd6, 3'd7, 2'd0));
		send_beat(make_op(K_LD_R_R, 3'd1, 3'd6, 2'd0));
		send_beat(make_op(K_PUSH, 3'd0, 3'd0, 2'd3));
		send_beat(make_op(K_POP_AF, 3'd0, 3'd0, 2'd0));
		send_beat(make_op(K_PUSH, 3'd0, 3'd0, 2'd2));
		send_beat(make_op(K_POP, 3'd0, 3'd0, 2'd0));
		send_beat(make_op(K_LD_HLI, 3'd0, 3'd0, 2'd0));
		send_beat(make_op(K_ST_HLD, 3'd0, 3'd0, 2'd0));
		send_beat(make_op(K_LD_SP_HL, 3'd0, 3'd0, 2'd0));
		send_beat(make_op(K_ST_NN_SP, 3'd0, 3'd0, 2'd0));
		send_beat(make_op(K_STH_C, 3'd0, 3'd0, 2'd0));
		send_beat(make_op(K_LDH_C, 3'd0, 3'd0, 2'd0));
		send_beat(make_op(K_STH_N, 3'd0, 3'd0, 2'd0));
		send_beat(make_op(K_LDH_N, 3'd0, 3'd0, 2'd0));
		send_beat(make_op(K_ST_NN_A, 3'd0, 3'd0, 2'd0));
		send_beat(make_op(K_LD_A_NN, 3'd0, 3'd0, 2'd0));
		send_beat(make_op(kind_t'(5'd31), 3'd0, 3'd0, 2'd0));
		send_beat(make_op(K_ST_RR_A, 3'd0, 3'd0, 2'd3));

		send_idle_pct = 36;
		recv_idle_pct = 78;
		run_phase(250);
		in_valid <= 1'b0;
		while (pending_count != 0) @(posedge clk);
		send_idle_pct = 78;
		recv_idle_pct = 36;
		run_phase(250);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		run_phase(250);
		in_valid <= 1'b0;
		while (pending_count != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (fail_count == 0) $display("tb_top passed");
		else $display("tb_top failed");
		$finish;
	end
endmodule
